/* src/wgm_pkg.sv */
// wgm_pkg: shared types and constants for the wildcard glob matcher
// holds word structs, action codes, pattern limits and cell control structs
// no dependencies
`timescale 1ns / 1ps

package wgm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int IDX_W       = $clog2(MAX_PATTERN);
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

   localparam logic [7:0] CH_STAR     = 8'd42;
   localparam logic [7:0] CH_QUESTION = 8'd63;
   localparam logic [7:0] CH_LOW      = 8'd32;
   localparam logic [7:0] CH_HIGH     = 8'd126;

   typedef enum logic [1:0] {
      ACT_PATTERN = 2'd0,
      ACT_TEXT    = 2'd1,
      ACT_CLEAR   = 2'd2
   } action_type;

   localparam logic KIND_FILTER = 1'b0;
   localparam logic KIND_MATCH  = 1'b1;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] symbol;
      logic       no_symbol;
      logic       last;
   } req_type;

   typedef struct packed {
      logic result_kind;
      logic ok;
   } rsp_type;

   // per-cycle control shared by every cell
   typedef struct packed {
      logic start;
      logic step;
      logic update;
      logic bank;
   } cell_ctrl_type;

   // pattern byte write into the staging bank
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [IDX_W-1:0] index;
      logic [7:0]       symbol;
      logic             lead;
   } cell_wr_type;

endpackage

/* src/wgm_cell.sv */
// wgm_cell: one pattern position, two banks of pattern byte plus leading-star flag
// and the live bit of that position; depends on wgm_pkg
`timescale 1ns / 1ps

module wgm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  wgm_pkg::cell_ctrl_type ctrl,
   input  wgm_pkg::cell_wr_type  wr,
   input  logic                  wr_sel,
   input  logic                  in_pat,
   input  logic                  start_bit,
   input  logic                  next_live,
   input  logic [7:0]            symbol,
   output logic                  cur_live,
   output logic                  star,
   output logic                  keep,
   output logic                  fwd,
   output logic                  lead
);
   import wgm_pkg::*;

   logic [7:0] pat0_ff;
   logic [7:0] pat1_ff;
   logic       lead0_ff;
   logic       lead1_ff;
   logic       live_ff;
   logic       live_in;
   logic [7:0] act_pat;
   logic       act_lead;
   logic       hit;

   always_ff @(posedge clock) begin
      if (wr_sel && !wr.bank) begin
         pat0_ff  <= wr.symbol;
         lead0_ff <= wr.lead;
      end
      if (wr_sel && wr.bank) begin
         pat1_ff  <= wr.symbol;
         lead1_ff <= wr.lead;
      end
   end

   assign act_pat  = ctrl.bank ? pat1_ff : pat0_ff;
   assign act_lead = ctrl.bank ? lead1_ff : lead0_ff;

   assign star     = in_pat & (act_pat == CH_STAR);
   assign hit      = in_pat & ~star & ((act_pat == CH_QUESTION) | (act_pat == symbol));
   assign cur_live = ctrl.start ? start_bit : live_ff;
   assign keep     = cur_live & star;
   assign fwd      = cur_live & hit;
   assign lead     = in_pat & act_lead;

   assign live_in = ctrl.update ? next_live : live_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
   end

endmodule

/* src/wgm_row.sv */
// wgm_row: row of pattern cells with the neighbour hand-off of live bits
// and the star closure across the row; depends on wgm_pkg and wgm_cell
`timescale 1ns / 1ps

module wgm_row (
   input  logic                         clock,
   input  logic                         reset,
   input  wgm_pkg::cell_ctrl_type        ctrl,
   input  wgm_pkg::cell_wr_type         wr,
   input  logic [wgm_pkg::LEN_W-1:0]    active_length,
   input  logic [7:0]                   symbol,
   output logic [wgm_pkg::MAX_PATTERN:0] live_next
);
   import wgm_pkg::*;

   logic [MAX_PATTERN-1:0] cur;
   logic [MAX_PATTERN-1:0] star;
   logic [MAX_PATTERN-1:0] keep;
   logic [MAX_PATTERN-1:0] fwd;
   logic [MAX_PATTERN-1:0] lead;
   logic [MAX_PATTERN-1:0] in_pat;
   logic [MAX_PATTERN-1:0] wr_sel;
   logic [MAX_PATTERN-1:0] start_vec;
   logic [MAX_PATTERN:0]   adv_vec;
   logic [MAX_PATTERN:0]   base_vec;
   logic [MAX_PATTERN:0]   s_vec;
   logic [MAX_PATTERN:0]   x_vec;
   logic [MAX_PATTERN:0]   sum_vec;
   logic [MAX_PATTERN:0]   carry_vec;
   logic                   cur_top;
   logic                   live_top_ff;
   logic                   live_top_in;

   assign start_vec[0] = 1'b1;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      if (i > 0) begin : g_start
         assign start_vec[i] = lead[i-1];
         assign adv_vec[i]   = keep[i] | fwd[i-1];
      end else begin : g_first
         assign adv_vec[i] = keep[i];
      end
      assign in_pat[i] = active_length > LEN_W'(i);
      assign wr_sel[i] = wr.en & (wr.index == IDX_W'(i));

      wgm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .wr        (wr),
         .wr_sel    (wr_sel[i]),
         .in_pat    (in_pat[i]),
         .start_bit (start_vec[i]),
         .next_live (live_next[i]),
         .symbol    (symbol),
         .cur_live  (cur[i]),
         .star      (star[i]),
         .keep      (keep[i]),
         .fwd       (fwd[i]),
         .lead      (lead[i])
      );
   end

   assign adv_vec[MAX_PATTERN] = fwd[MAX_PATTERN-1];
   assign cur_top  = ctrl.start ? lead[MAX_PATTERN-1] : live_top_ff;
   assign base_vec = ctrl.step ? adv_vec : {cur_top, cur};

   // star closure: carries run from a live star through its run of stars
   assign s_vec     = {1'b0, star};
   assign x_vec     = base_vec & s_vec;
   assign sum_vec   = s_vec + x_vec;
   assign carry_vec = sum_vec ^ s_vec ^ x_vec;
   assign live_next = base_vec | carry_vec;

   assign live_top_in = ctrl.update ? live_next[MAX_PATTERN] : live_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_top_ff <= 1'b0;
      end else begin
         live_top_ff <= live_top_in;
      end
   end

endmodule

/* src/wildcard_glob_matcher.sv */
// wildcard_glob_matcher: top level, pattern load control, string tracking and
// the registered result stage with skid; depends on wgm_pkg and wgm_row
//
//   channel   ports                               direction   word
//   request   req_valid req_stall req_data        in          wgm_pkg::req_type
//   response  rsp_valid rsp_stall rsp_data        out         wgm_pkg::rsp_type
//
// one request word is taken every cycle while req_stall is low, pattern and text alike
// a result goes into the result register, or into the skid entry while rsp_stall holds it
// the clock period is set by the 33-bit star closure add across the cell row
// reset is synchronous; no clearing pass, the pattern banks need none
// result register plus one skid entry; req_stall is high while the skid is full
`timescale 1ns / 1ps

module wildcard_glob_matcher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wgm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wgm_pkg::rsp_type rsp_data
);
   import wgm_pkg::*;

   logic                 active_bank_ff, active_bank_in;
   logic [LEN_W-1:0]     active_length_ff, active_length_in;
   logic                 filter_present_ff, filter_present_in;
   logic [LEN_W-1:0]     staging_length_ff, staging_length_in;
   logic                 staging_bad_ff, staging_bad_in;
   logic                 staging_lead_ff, staging_lead_in;
   logic                 at_string_start_ff, at_string_start_in;
   logic                 text_ended_ff, text_ended_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   rsp_type              skid_data_ff, skid_data_in;

   logic                 accept;
   logic                 present;
   logic                 bad_byte;
   logic                 full;
   logic                 do_store;
   logic [LEN_W-1:0]     len_n;
   logic                 bad_n;
   logic                 new_lead;
   logic                 ended_eff;
   logic                 text_step;
   logic                 text_zero;
   logic                 has_res;
   rsp_type              res_data;
   logic                 out_free;
   cell_ctrl_type        ctrl;
   cell_wr_type          wr;
   logic [MAX_PATTERN:0] live_next;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign present   = ~req_data.no_symbol;

   assign bad_byte = present & ((req_data.symbol < CH_LOW) | (req_data.symbol > CH_HIGH));
   assign full     = present & (staging_length_ff >= LEN_W'(MAX_PATTERN));
   assign do_store = present & ~full;
   assign len_n    = staging_length_ff + LEN_W'(do_store);
   assign bad_n    = staging_bad_ff | bad_byte | full;
   assign new_lead = staging_lead_ff & (req_data.symbol == CH_STAR);

   assign ended_eff = ~at_string_start_ff & text_ended_ff;
   assign text_step = present & ~ended_eff & (req_data.symbol != 8'd0);
   assign text_zero = present & ~ended_eff & (req_data.symbol == 8'd0);

   assign ctrl.start  = at_string_start_ff;
   assign ctrl.step   = text_step;
   assign ctrl.update = accept & (req_data.action == ACT_TEXT);
   assign ctrl.bank   = active_bank_ff;

   assign wr.en     = accept & (req_data.action == ACT_PATTERN) & do_store;
   assign wr.bank   = ~active_bank_ff;
   assign wr.index  = staging_length_ff[IDX_W-1:0];
   assign wr.symbol = req_data.symbol;
   assign wr.lead   = new_lead;

   wgm_row u_row (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .wr            (wr),
      .active_length (active_length_ff),
      .symbol        (req_data.symbol),
      .live_next     (live_next)
   );

   always_comb begin
      active_bank_in     = active_bank_ff;
      active_length_in   = active_length_ff;
      filter_present_in  = filter_present_ff;
      staging_length_in  = staging_length_ff;
      staging_bad_in     = staging_bad_ff;
      staging_lead_in    = staging_lead_ff;
      at_string_start_in = at_string_start_ff;
      text_ended_in      = text_ended_ff;
      has_res            = 1'b0;
      res_data           = '0;
      if (accept) begin
         case (req_data.action)
            ACT_PATTERN: begin
               staging_length_in = len_n;
               staging_bad_in    = bad_n;
               if (do_store) begin
                  staging_lead_in = new_lead;
               end
               if (req_data.last) begin
                  has_res              = 1'b1;
                  res_data.result_kind = KIND_FILTER;
                  res_data.ok          = ~bad_n;
                  if (!bad_n) begin
                     active_bank_in     = ~active_bank_ff;
                     active_length_in   = len_n;
                     filter_present_in  = 1'b1;
                     at_string_start_in = 1'b1;
                  end
                  staging_length_in = '0;
                  staging_bad_in    = 1'b0;
                  staging_lead_in   = 1'b1;
               end
            end
            ACT_TEXT: begin
               at_string_start_in = 1'b0;
               text_ended_in      = ended_eff | text_zero;
               if (req_data.last) begin
                  has_res              = 1'b1;
                  res_data.result_kind = KIND_MATCH;
                  res_data.ok          = filter_present_ff ? live_next[active_length_ff] : 1'b1;
                  at_string_start_in   = 1'b1;
                  text_ended_in        = 1'b0;
               end
            end
            ACT_CLEAR: begin
               filter_present_in    = 1'b0;
               staging_length_in    = '0;
               staging_bad_in       = 1'b0;
               staging_lead_in      = 1'b1;
               at_string_start_in   = 1'b1;
               has_res              = 1'b1;
               res_data.result_kind = KIND_FILTER;
               res_data.ok          = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // result register with one skid entry
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = has_res;
            rsp_data_in  = res_data;
         end
      end else if (has_res) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_bank_ff     <= 1'b0;
         active_length_ff   <= '0;
         filter_present_ff  <= 1'b0;
         staging_length_ff  <= '0;
         staging_bad_ff     <= 1'b0;
         staging_lead_ff    <= 1'b1;
         at_string_start_ff <= 1'b1;
         text_ended_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         active_bank_ff     <= active_bank_in;
         active_length_ff   <= active_length_in;
         filter_present_ff  <= filter_present_in;
         staging_length_ff  <= staging_length_in;
         staging_bad_ff     <= staging_bad_in;
         staging_lead_ff    <= staging_lead_in;
         at_string_start_ff <= at_string_start_in;
         text_ended_ff      <= text_ended_in;
         rsp_valid_ff       <= rsp_valid_in;
         skid_valid_ff      <= skid_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while result register empty");

   a_load_takes_effect: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.action == ACT_PATTERN && req_data.last && !bad_n)
      |=> (filter_present_ff && at_string_start_ff))
      else $error("accepted pattern not in force");

   a_clear_drops_filter: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.action == ACT_CLEAR) |=> !filter_present_ff)
      else $error("filter still present after clear");

   a_length_in_range: assert property (@(posedge clock) disable iff (reset)
      (active_length_ff <= LEN_W'(MAX_PATTERN)) && (staging_length_ff <= LEN_W'(MAX_PATTERN)))
      else $error("pattern length beyond row");

endmodule

/* dv/tb_wildcard_glob_matcher.sv */
// tb_wildcard_glob_matcher: self-checking testbench for the wildcard glob matcher
// drives pattern, text, clear and unused words, predicts each outcome and checks it in order
// depends on wgm_pkg and wildcard_glob_matcher
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher;
   import wgm_pkg::*;

   typedef logic [7:0] sym_list_type[$];

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 300000;
   localparam int         RANDOM_WORDS = 570;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   wildcard_glob_matcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // words waiting to be sent and outcomes waiting to arrive
   req_type pending_words[$];
   rsp_type outcomes_due[$];
   int      words_made   = 0;
   int      words_taken  = 0;
   int      words_total  = 1;
   int      fail_count   = 0;
   int      cycle_count  = 0;
   bit      req_took     = 1'b0;
   string   text_chars   = "abc";
   string   glob_chars   = "ab*?";

   // matcher state mirror
   logic [7:0]       pat_bank [2][MAX_PATTERN];
   bit               act_bank  = 1'b0;
   int               act_len   = 0;
   bit               filt_on   = 1'b0;
   int               stage_len = 0;
   bit               stage_bad = 1'b0;
   bit [MAX_PATTERN:0] live    = '0;
   bit               str_start = 1'b1;
   bit               str_done  = 1'b0;

   function automatic void close_stars();
      for (int i = 0; i < act_len; i++)
         if (live[i] && pat_bank[act_bank][i] == CH_STAR)
            live[i+1] = 1'b1;
   endfunction

   function automatic void glob_step(req_type w);
      rsp_type            r;
      bit [MAX_PATTERN:0] nxt;
      logic [7:0]         p;
      case (w.action)
         ACT_CLEAR: begin
            filt_on       = 1'b0;
            stage_len     = 0;
            stage_bad     = 1'b0;
            str_start     = 1'b1;
            r.result_kind = KIND_FILTER;
            r.ok          = 1'b1;
            outcomes_due.push_back(r);
         end
         ACT_PATTERN: begin
            if (!w.no_symbol) begin
               if (w.symbol < CH_LOW || w.symbol > CH_HIGH)
                  stage_bad = 1'b1;
               if (stage_len >= MAX_PATTERN) begin
                  stage_bad = 1'b1;
               end else begin
                  pat_bank[!act_bank][stage_len] = w.symbol;
                  stage_len++;
               end
            end
            if (w.last) begin
               r.result_kind = KIND_FILTER;
               r.ok          = !stage_bad;
               if (r.ok) begin
                  act_bank  = !act_bank;
                  act_len   = stage_len;
                  filt_on   = 1'b1;
                  str_start = 1'b1;
               end
               stage_len = 0;
               stage_bad = 1'b0;
               outcomes_due.push_back(r);
            end
         end
         ACT_TEXT: begin
            if (str_start) begin
               live    = '0;
               live[0] = 1'b1;
               close_stars();
               str_start = 1'b0;
               str_done  = 1'b0;
            end
            if (!w.no_symbol && !str_done) begin
               if (w.symbol == 8'd0) begin
                  str_done = 1'b1;
               end else begin
                  nxt = '0;
                  for (int i = 0; i < act_len; i++) begin
                     p = pat_bank[act_bank][i];
                     if (live[i]) begin
                        if (p == CH_STAR)
                           nxt[i] = 1'b1;
                        else if (p == CH_QUESTION || p == w.symbol)
                           nxt[i+1] = 1'b1;
                     end
                  end
                  live = nxt;
                  close_stars();
               end
            end
            if (w.last) begin
               r.result_kind = KIND_MATCH;
               r.ok          = filt_on ? live[act_len] : 1'b1;
               str_start     = 1'b1;
               str_done      = 1'b0;
               outcomes_due.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic add_word(logic [1:0] act, logic [7:0] sym, logic ns, logic lst);
      req_type w;
      w.action    = act;
      w.symbol    = sym;
      w.no_symbol = ns;
      w.last      = lst;
      pending_words.push_back(w);
      if (act != ACT_UNUSED)
         words_made++;
   endtask

   // bytes of a sequence, with stray empty words and sometimes an empty closing word
   task automatic send_seq(logic [1:0] act, sym_list_type seq, bit closing);
      bit empty_tail;
      empty_tail = closing && (seq.size() == 0 || $urandom_range(9) == 0);
      for (int i = 0; i < seq.size(); i++) begin
         if ($urandom_range(19) == 0)
            add_word(act, 8'($urandom), 1'b1, 1'b0);
         add_word(act, seq[i], 1'b0, closing && !empty_tail && i == seq.size() - 1);
      end
      if (empty_tail)
         add_word(act, 8'($urandom), 1'b1, 1'b1);
   endtask

   function automatic sym_list_type syms_of(string s);
      sym_list_type q;
      for (int i = 0; i < s.len(); i++)
         q.push_back(s[i]);
      return q;
   endfunction

   function automatic logic [7:0] bad_sym();
      if ($urandom_range(1))
         return 8'($urandom_range(31, 0));
      return 8'($urandom_range(255, 127));
   endfunction

   function automatic sym_list_type rand_glob(int len);
      sym_list_type q;
      for (int i = 0; i < len; i++)
         if ($urandom_range(9) == 0)
            q.push_back(8'($urandom_range(CH_HIGH, CH_LOW)));
         else
            q.push_back(glob_chars[$urandom_range(3)]);
      return q;
   endfunction

   // text that follows the pattern, sometimes with one byte changed
   function automatic sym_list_type text_for(sym_list_type pat);
      sym_list_type q;
      for (int i = 0; i < pat.size(); i++)
         if (pat[i] == CH_STAR)
            repeat ($urandom_range(3)) q.push_back(text_chars[$urandom_range(2)]);
         else if (pat[i] == CH_QUESTION)
            q.push_back(text_chars[$urandom_range(2)]);
         else
            q.push_back(pat[i]);
      if (q.size() != 0 && $urandom_range(9) < 3)
         q[$urandom_range(q.size() - 1)] = text_chars[$urandom_range(2)];
      return q;
   endfunction

   function automatic sym_list_type rand_text();
      sym_list_type q;
      int           r;
      repeat ($urandom_range(8)) begin
         r = $urandom_range(99);
         if (r < 5)
            q.push_back(8'($urandom_range(255, 1)));
         else if (r < 8)
            q.push_back(8'd0);
         else
            q.push_back(text_chars[$urandom_range(2)]);
      end
      return q;
   endfunction

   // request driver
   always @(negedge clock) begin
      int phase;
      int idle_pct;
      int stall_pct;
      phase     = words_taken * 4 / words_total;
      idle_pct  = (phase == 1) ? 76 : (phase >= 3) ? 22 : 0;
      stall_pct = (phase == 2) ? 76 : (phase >= 3) ? 22 : 0;
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (!req_valid || req_took) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_words[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_type want;
      req_took = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            glob_step(req_data);
            pending_words.delete(0);
            words_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (outcomes_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word, expected none, actual kind=%0d ok=%0d",
                        $time, rsp_data.result_kind, rsp_data.ok);
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_data.result_kind !== want.result_kind) begin
                  fail_count++;
                  $display("%0t: result_kind mismatch, expected %0d actual %0d",
                           $time, want.result_kind, rsp_data.result_kind);
               end
               if (rsp_data.ok !== want.ok) begin
                  fail_count++;
                  $display("%0t: ok mismatch, expected %0d actual %0d",
                           $time, want.ok, rsp_data.ok);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      sym_list_type seq;
      sym_list_type gen_pat;
      int           pick;
      int           kind;
      int           words_goal;

      // no filter yet
      add_word(ACT_TEXT, 8'hFF, 1'b1, 1'b1);
      send_seq(ACT_TEXT, syms_of("ab"), 1'b1);
      add_word(ACT_CLEAR, 8'hFF, 1'b1, 1'b1);
      // empty pattern only matches the empty string
      add_word(ACT_PATTERN, 8'h00, 1'b1, 1'b1);
      add_word(ACT_TEXT, 8'h00, 1'b1, 1'b1);
      send_seq(ACT_TEXT, syms_of("a"), 1'b1);
      // printable extremes in the pattern
      send_seq(ACT_PATTERN, syms_of("a*b?~ "), 1'b1);
      send_seq(ACT_TEXT, syms_of("axxb!~ "), 1'b1);
      send_seq(ACT_TEXT, syms_of("ab~ "), 1'b1);
      // rejected patterns keep the old one
      add_word(ACT_PATTERN, 8'h61, 1'b0, 1'b0);
      add_word(ACT_PATTERN, 8'h7F, 1'b0, 1'b1);
      add_word(ACT_PATTERN, 8'h1F, 1'b0, 1'b1);
      add_word(ACT_PATTERN, 8'h00, 1'b0, 1'b1);
      add_word(ACT_PATTERN, 8'hFF, 1'b0, 1'b1);
      // zero byte ends the text early
      seq = syms_of("axbc~ ");
      seq.push_back(8'd0);
      seq.push_back(8'h7A);
      send_seq(ACT_TEXT, seq, 1'b1);
      add_word(ACT_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
      // clear during a load, then a text with no filter
      send_seq(ACT_PATTERN, syms_of("zz"), 1'b0);
      add_word(ACT_CLEAR, 8'($urandom), 1'b0, 1'b0);
      send_seq(ACT_TEXT, syms_of("q"), 1'b1);
      // new filter during a text restarts the string, and so does a clear during a text
      send_seq(ACT_PATTERN, syms_of("*"), 1'b1);
      send_seq(ACT_TEXT, syms_of("xy"), 1'b0);
      send_seq(ACT_PATTERN, syms_of("?"), 1'b1);
      send_seq(ACT_TEXT, syms_of("y"), 1'b1);
      send_seq(ACT_TEXT, syms_of("ab"), 1'b0);
      add_word(ACT_CLEAR, 8'($urandom), 1'b1, 1'b0);
      send_seq(ACT_TEXT, syms_of("abc"), 1'b1);
      // full length and over-long patterns
      gen_pat = rand_glob(MAX_PATTERN);
      send_seq(ACT_PATTERN, gen_pat, 1'b1);
      send_seq(ACT_TEXT, text_for(gen_pat), 1'b1);
      send_seq(ACT_PATTERN, rand_glob(MAX_PATTERN + 2), 1'b1);
      send_seq(ACT_TEXT, text_for(gen_pat), 1'b1);

      words_goal = words_made + RANDOM_WORDS;
      while (words_made < words_goal) begin
         pick = $urandom_range(99);
         if (pick < 14) begin
            seq  = rand_glob(($urandom_range(9) < 8) ? $urandom_range(8)
                                                     : $urandom_range(MAX_PATTERN, 9));
            kind = $urandom_range(9);
            if (kind == 0 && seq.size() != 0)
               seq[$urandom_range(seq.size() - 1)] = bad_sym();
            else if (kind == 1)
               seq = rand_glob($urandom_range(MAX_PATTERN + 4, MAX_PATTERN + 1));
            else
               gen_pat = seq;
            send_seq(ACT_PATTERN, seq, 1'b1);
         end else if (pick < 18) begin
            add_word(ACT_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
         end else if (pick < 20) begin
            add_word(ACT_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
         end else if (pick < 22) begin
            send_seq(ACT_PATTERN, rand_glob($urandom_range(5, 1)), 1'b0);
            add_word(ACT_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
         end else if (pick < 25) begin
            send_seq(ACT_TEXT, rand_text(), 1'b0);
            gen_pat = rand_glob($urandom_range(5));
            send_seq(ACT_PATTERN, gen_pat, 1'b1);
         end else if (pick < 70) begin
            send_seq(ACT_TEXT, text_for(gen_pat), 1'b1);
         end else begin
            send_seq(ACT_TEXT, rand_text(), 1'b1);
         end
      end
      words_total = pending_words.size();

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || outcomes_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
